// ===== hdl/lruco_pkg.sv =====
// lruco_pkg: shared widths, action codes and defaults for the LRU order tracker.
// No dependencies; imported by lruco_ram and lru_cache_order_tracker_core.
`timescale 1ns / 1ps

package lruco_pkg;

   localparam int KEY_W        = 5;
   localparam int ACT_W        = 2;
   localparam int CFG_W        = 5;
   localparam int CAPACITY_DEF = 16;
   localparam int NUM_LETTERS  = 26;
   localparam int SIZE_RESET   = 16;

   typedef logic [KEY_W-1:0] key_type;

   localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

endpackage

// ===== hdl/lruco_ram.sv =====
// lruco_ram: one-write, one-read synchronous RAM holding the recency list.
// Read data is registered. Depends on lruco_pkg.
`timescale 1ns / 1ps

module lruco_ram
   import lruco_pkg::*;
#(
   parameter int DEPTH  = CAPACITY_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  key_type           wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output key_type           rd_data_ff
);

   key_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== hdl/lru_cache_order_tracker_core.sv =====
// lru_cache_order_tracker_core: LRU-ordered letter cache with access, dump and clear.
// Depends on lruco_pkg and lruco_ram.
`timescale 1ns / 1ps

// One request at a time; busy is high while a request is in progress. The recency
// list sits in a single-port-read RAM, slot 0 least recent. Each cycle moves one
// slot through the RAM read port; an access scans for the key, then closes the gap
// and writes it on top, while a first insert, a clear or an empty dump completes
// without busy going high, and a dump reads the slots out in order. Dump results
// appear one per cycle on rsp_strobe and cannot be held off by the receiver.
// Writing csr_cache_size also empties the cache.

module lru_cache_order_tracker_core
   import lruco_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [ACT_W-1:0] req_action,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_strobe,
   output logic [KEY_W-1:0] rsp_entry_key,
   output logic             rsp_empty_res,
   output logic             rsp_last,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_cache_size
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DUMP  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CFG_W-1:0] size_ff, size_in;
   key_type          key_ff, key_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] dst_ff, dst_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] pend_idx_ff, pend_idx_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   key_type          rsp_key_ff, rsp_key_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   key_type          wr_data;
   key_type          rd_data;
   logic [CNT_W-1:0] held_last;
   logic [CNT_W-1:0] eff_size;
   logic             issue;

   lruco_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (ptr_ff[IDX_W-1:0]),
      .rd_data_ff (rd_data)
   );

   assign held_last = held_ff - CNT_W'(1);
   assign issue     = (ptr_ff < held_ff);

   // zero acts as one, oversize clamps to the built capacity
   always_comb begin
      if (size_ff == '0) begin
         eff_size = CNT_W'(1);
      end else if (size_ff > CFG_W'(CAPACITY)) begin
         eff_size = CNT_W'(CAPACITY);
      end else begin
         eff_size = CNT_W'(size_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      size_in       = size_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      dst_in        = dst_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_key_in    = rsp_key_ff;
      rsp_empty_in  = 1'b0;
      rsp_last_in   = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = key_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_ACCESS: begin
                     if (req_key < KEY_W'(NUM_LETTERS)) begin
                        key_in = req_key;
                        if (held_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_addr = '0;
                           wr_data = req_key;
                           held_in = CNT_W'(1);
                        end else begin
                           state_in = ST_SCAN;
                           ptr_in   = '0;
                        end
                     end
                  end
                  ACT_DUMP: begin
                     if (held_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_key_in    = '0;
                        rsp_empty_in  = 1'b1;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = ST_DUMP;
                        ptr_in   = '0;
                     end
                  end
                  ACT_CLEAR: begin
                     held_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
            if (csr_wr_en) begin
               size_in = csr_cache_size;
               held_in = '0;
            end
         end

         ST_SCAN: begin
            if (issue) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff;
               ptr_in      = ptr_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (rd_data == key_ff) begin
                  // hit: close the gap above the hit slot
                  state_in = ST_SHIFT;
                  pend_in  = 1'b0;
                  dst_in   = pend_idx_ff;
                  ptr_in   = pend_idx_ff + CNT_W'(1);
               end else if (pend_idx_ff == held_last) begin
                  if (held_ff < eff_size) begin
                     wr_en    = 1'b1;
                     wr_addr  = held_ff[IDX_W-1:0];
                     held_in  = held_ff + CNT_W'(1);
                     state_in = ST_IDLE;
                     pend_in  = 1'b0;
                  end else begin
                     // full: evict slot 0
                     state_in = ST_SHIFT;
                     pend_in  = 1'b0;
                     dst_in   = '0;
                     ptr_in   = CNT_W'(1);
                  end
               end
            end
         end

         ST_SHIFT: begin
            if (issue) begin
               pend_in = 1'b1;
               ptr_in  = ptr_ff + CNT_W'(1);
            end
            if (dst_ff == held_last) begin
               wr_en    = 1'b1;
               wr_addr  = dst_ff[IDX_W-1:0];
               state_in = ST_IDLE;
               pend_in  = 1'b0;
            end else if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff[IDX_W-1:0];
               wr_data = rd_data;
               dst_in  = dst_ff + CNT_W'(1);
            end
         end

         ST_DUMP: begin
            if (issue) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff;
               ptr_in      = ptr_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_key_in    = rd_data;
               rsp_last_in   = (pend_idx_ff == held_last);
               if (pend_idx_ff == held_last) begin
                  state_in = ST_IDLE;
                  pend_in  = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         size_ff       <= CFG_W'(SIZE_RESET);
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         size_ff       <= size_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      ptr_ff       <= ptr_in;
      dst_ff       <= dst_in;
      pend_idx_ff  <= pend_idx_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_entry_key = rsp_key_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
